// ===== sv/pcprm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcprm_pkg
// Shared types, constants and helper functions for the per-channel
// position running mean core.
// ----------------------------------------------------------------------------
package pcprm_pkg;

  // Detector geometry.
  localparam int PANELS      = 2;
  localparam int CARTRIDGES  = 2;
  localparam int DAQS        = 4;
  localparam int CHIPS       = 8;
  localparam int MODULES     = 4;
  localparam int DIODES      = 2;
  localparam int SAMPLE_BITS = 16;

  // Field widths of the beats.
  localparam int FIELD_W = 16;
  localparam int BIN_W   = 10;
  localparam int CNT_W   = 24;
  localparam int MEAN_W  = 24;

  // Storage and arithmetic sizing.
  localparam int BIN_DEPTH = PANELS * CARTRIDGES * DAQS * CHIPS * MODULES * DIODES;
  localparam int FRAC_BITS = 8;
  localparam int DIFF_W    = MEAN_W + FRAC_BITS + 1;
  localparam int SUM_W     = DIFF_W + 2;
  localparam int DIV_STEPS = DIFF_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int WORD_W    = CNT_W + 2 * MEAN_W;
  localparam int SMP_W     = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;

  localparam logic [CNT_W-1:0]          COUNT_MAX = '1;
  localparam logic signed [MEAN_W-1:0]  MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0]  MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_DIV,
    ST_FIX,
    ST_WRITE,
    ST_OUT
  } state_e;

  // Takes the sample from the low SAMPLE_BITS of a field as two's complement.
  // When the sample is wider than the field, the field is zero extended.
  function automatic logic signed [MEAN_W-1:0] sample_ext(input logic [FIELD_W-1:0] f);
    logic signed [MEAN_W-1:0] x;
    for (int i = 0; i < MEAN_W; i++) begin
      if (i < SMP_W) begin
        x[i] = f[i];
      end else if (SAMPLE_BITS <= FIELD_W) begin
        x[i] = f[SMP_W-1];
      end else begin
        x[i] = 1'b0;
      end
    end
    return x;
  endfunction

  // Flattened bin address of a coordinate set and photodiode.
  function automatic logic [BIN_W-1:0] bin_addr(input logic       p,
                                                input logic       c,
                                                input logic [1:0] d,
                                                input logic [2:0] r,
                                                input logic [1:0] m,
                                                input logic       diode);
    int a;
    a = ((((int'(p) * CARTRIDGES + int'(c)) * DAQS + int'(d)) * CHIPS + int'(r))
         * MODULES + int'(m)) * DIODES + int'(diode);
    if (a >= BIN_DEPTH) begin
      a = 0;
    end
    return BIN_W'(a);
  endfunction

endpackage

// ===== sv/per_channel_position_running_mean_core.sv =====
// ----------------------------------------------------------------------------
// per_channel_position_running_mean_core
// Keeps a running mean of u/v event positions for every detector bin.
// ----------------------------------------------------------------------------
// Each input beat is one decoded event. The photodiode with the strictly
// larger common signal is chosen, the coordinates and diode select one of
// 1024 bins, and the bin's count and u/v means (8 fraction bits) are updated
// as mean += (x - mean) / count. A single restoring divider produces one
// quotient bit per cycle, 33 bits per mean, and runs once for u and once for
// v. An accepted event runs through read, then setup, divide and fix for u
// and again for v, then write and output; the next event is taken only once
// the result is loaded, so events do not overlap. An event with an
// out-of-range coordinate leaves the stores alone and goes straight to the
// output step. If the previous result has not been taken when a new one is
// ready, the block waits until it is.
// After reset the block runs a clearing pass over the bin memory, one entry
// per cycle, with in_ready_o low. A new event is taken while the previous
// result still waits in the output register.
module per_channel_position_running_mean_core
  import pcprm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     panel_num_i,
  input  logic                     cartridge_num_i,
  input  logic [1:0]               daq_num_i,
  input  logic [2:0]               chip_num_i,
  input  logic [1:0]               module_num_i,
  input  logic signed [FIELD_W-1:0] u_first_i,
  input  logic signed [FIELD_W-1:0] v_first_i,
  input  logic signed [FIELD_W-1:0] u_second_i,
  input  logic signed [FIELD_W-1:0] v_second_i,
  input  logic signed [FIELD_W-1:0] common_first_i,
  input  logic signed [FIELD_W-1:0] common_second_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [BIN_W-1:0]         bin_index_o,
  output logic                     diode_chosen_o,
  output logic [CNT_W-1:0]         bin_count_o,
  output logic signed [MEAN_W-1:0] mean_u_out_o,
  output logic signed [MEAN_W-1:0] mean_v_out_o,
  output logic                     index_error_o
);

  // Control state.
  state_e               state_q, state_d;
  logic [BIN_W-1:0]     clr_addr_q;
  logic [STEP_W-1:0]    step_q;
  logic                 sel_q;
  logic                 out_valid_q;

  // Event and arithmetic registers.
  logic                     diode_q;
  logic                     err_q;
  logic [BIN_W-1:0]         idx_q;
  logic signed [MEAN_W-1:0] xu_q, xv_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic                     neg_q;
  logic [CNT_W-1:0]         rem_q;
  logic [DIFF_W-1:0]        quo_q;
  logic signed [MEAN_W-1:0] mu_new_q, mv_new_q;

  // Bin memory: {count, mean_v, mean_u} per entry.
  logic [WORD_W-1:0]        bin_mem_q [BIN_DEPTH];
  logic [WORD_W-1:0]        rd_data_q;

  // Output register payload.
  logic [BIN_W-1:0]         bin_index_q;
  logic                     diode_out_q;
  logic [CNT_W-1:0]         bin_count_q;
  logic signed [MEAN_W-1:0] mean_u_q, mean_v_q;
  logic                     index_error_q;

  // Strobes from the sequencer.
  logic in_fire;
  logic out_load;
  logic mem_we;
  logic [BIN_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Event decode on the input beat.
  logic             diode_w;
  logic             err_w;
  logic [BIN_W-1:0] idx_w;

  assign diode_w = common_second_i > common_first_i;
  assign err_w   = (int'(panel_num_i) >= PANELS) || (int'(cartridge_num_i) >= CARTRIDGES) ||
                   (int'(daq_num_i) >= DAQS) || (int'(chip_num_i) >= CHIPS) ||
                   (int'(module_num_i) >= MODULES);
  assign idx_w   = bin_addr(panel_num_i, cartridge_num_i, daq_num_i, chip_num_i,
                            module_num_i, diode_w);

  // Fields of the stored word.
  logic signed [MEAN_W-1:0] rd_mean_u, rd_mean_v;
  logic [CNT_W-1:0]         rd_cnt;

  assign rd_mean_u = rd_data_q[MEAN_W-1:0];
  assign rd_mean_v = rd_data_q[2*MEAN_W-1:MEAN_W];
  assign rd_cnt    = rd_data_q[WORD_W-1:2*MEAN_W];

  // Divider setup: signed difference split into sign and magnitude.
  logic signed [MEAN_W-1:0] mean_op, x_op;
  logic signed [DIFF_W-1:0] x_ext, m_ext, diff_w;
  logic [DIFF_W-1:0]        mag_w;

  assign mean_op = sel_q ? rd_mean_v : rd_mean_u;
  assign x_op    = sel_q ? xv_q : xu_q;
  assign x_ext   = DIFF_W'(x_op);
  assign m_ext   = DIFF_W'(mean_op);
  assign diff_w  = (x_ext <<< FRAC_BITS) - m_ext;
  assign mag_w   = diff_w[DIFF_W-1] ? DIFF_W'(-diff_w) : DIFF_W'(diff_w);

  // One restoring division step: trial subtract of the count.
  logic [CNT_W+1:0] trial_w;
  logic             qbit_w;

  assign trial_w = {1'b0, rem_q, quo_q[DIFF_W-1]} - {2'b00, cnt_q};
  assign qbit_w  = !trial_w[CNT_W+1];

  // Mean update with saturation to the mean range.
  logic signed [SUM_W-1:0]  q_ext, mean_ext, sum_w;
  logic signed [MEAN_W-1:0] res_w;

  assign q_ext    = $signed({2'b00, quo_q});
  assign mean_ext = SUM_W'(mean_q);
  assign sum_w    = neg_q ? (mean_ext - q_ext) : (mean_ext + q_ext);

  always_comb begin
    if (sum_w > SUM_W'(MEAN_MAX)) begin
      res_w = MEAN_MAX;
    end else if (sum_w < SUM_W'(MEAN_MIN)) begin
      res_w = MEAN_MIN;
    end else begin
      res_w = sum_w[MEAN_W-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == BIN_W'(BIN_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = err_w ? ST_OUT : ST_READ;
      end
      ST_READ:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(1)) state_d = ST_FIX;
      end
      ST_FIX:   state_d = sel_q ? ST_WRITE : ST_SETUP;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
    mem_we     = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
    mem_waddr  = (state_q == ST_CLEAR) ? clr_addr_q : idx_q;
    mem_wdata  = (state_q == ST_CLEAR) ? '0 : {cnt_q, mv_new_q, mu_new_q};
  end

  assign in_fire = in_valid_i && in_ready_o;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      step_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + BIN_W'(1);
      if (state_q == ST_SETUP) begin
        step_q <= STEP_W'(DIV_STEPS);
      end else if (state_q == ST_DIV) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (in_fire) begin
        sel_q <= 1'b0;
      end else if (state_q == ST_FIX) begin
        sel_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event capture, divider and mean datapath.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diode_q <= diode_w;
      err_q   <= err_w;
      idx_q   <= idx_w;
      xu_q    <= sample_ext(diode_w ? u_second_i : u_first_i);
      xv_q    <= sample_ext(diode_w ? v_second_i : v_first_i);
    end
    if (state_q == ST_SETUP) begin
      mean_q <= mean_op;
      neg_q  <= diff_w[DIFF_W-1];
      rem_q  <= '0;
      quo_q  <= mag_w;
      if (!sel_q) cnt_q <= (rd_cnt < COUNT_MAX) ? rd_cnt + CNT_W'(1) : rd_cnt;
    end
    if (state_q == ST_DIV) begin
      rem_q <= qbit_w ? trial_w[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[DIFF_W-1]};
      quo_q <= {quo_q[DIFF_W-2:0], qbit_w};
    end
    if (state_q == ST_FIX) begin
      if (sel_q) begin
        mv_new_q <= res_w;
      end else begin
        mu_new_q <= res_w;
      end
    end
  end

  // Bin memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) bin_mem_q[mem_waddr] <= mem_wdata;
    if (state_q == ST_READ) rd_data_q <= bin_mem_q[idx_q];
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      diode_out_q   <= diode_q;
      index_error_q <= err_q;
      bin_index_q   <= err_q ? '0 : idx_q;
      bin_count_q   <= err_q ? '0 : cnt_q;
      mean_u_q      <= err_q ? '0 : mu_new_q;
      mean_v_q      <= err_q ? '0 : mv_new_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bin_index_o    = bin_index_q;
  assign diode_chosen_o = diode_out_q;
  assign bin_count_o    = bin_count_q;
  assign mean_u_out_o   = mean_u_q;
  assign mean_v_out_o   = mean_v_q;
  assign index_error_o  = index_error_q;

  // An accepted beat goes either to the memory read or straight to the result.
  a_accept_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_READ) || (state_q == ST_OUT))
    else $error("accepted beat did not start a read or an error result");

  // A valid update always reports a nonzero count.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !index_error_o |-> bin_count_o != '0)
    else $error("update result with zero count");

  // A flagged beat reports zero address, count and means.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |->
      (bin_index_o == '0) && (bin_count_o == '0) &&
      (mean_u_out_o == '0) && (mean_v_out_o == '0))
    else $error("error result carries nonzero fields");

  // The divider never runs with an exhausted step counter.
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> step_q != '0)
    else $error("divider step counter underflow");

endmodule

// ===== tb/tb_per_channel_position_running_mean_core.sv =====
// ----------------------------------------------------------------------------
// tb_per_channel_position_running_mean_core
// Self-checking testbench for the per-channel position running mean core.
// ----------------------------------------------------------------------------
// Events are sent on the input channel and predicted by a local copy of the
// bin stores. Every result beat is compared field by field with the oldest
// prediction. A short directed part covers the coordinate extremes, the
// photodiode choice and the truncating mean update. A random part follows
// that concentrates on a few busy bins so that counts grow large. Both
// channels idle and stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module tb_per_channel_position_running_mean_core;
  import pcprm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_EVENTS  = 1000;
  localparam int HOT_SITES      = 6;
  localparam int DRAIN_CYCLES   = 160;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int REPORT_LIMIT   = 10;

  // One decoded detector event.
  typedef struct packed {
    logic               panel;
    logic               cartridge;
    logic [1:0]         daq;
    logic [2:0]         chip;
    logic [1:0]         mod_num;
    logic [FIELD_W-1:0] u_first;
    logic [FIELD_W-1:0] v_first;
    logic [FIELD_W-1:0] u_second;
    logic [FIELD_W-1:0] v_second;
    logic [FIELD_W-1:0] common_first;
    logic [FIELD_W-1:0] common_second;
  } pos_event_t;

  // One updated bin as reported by the block.
  typedef struct packed {
    logic [BIN_W-1:0]  bin_index;
    logic              diode_chosen;
    logic [CNT_W-1:0]  bin_count;
    logic [MEAN_W-1:0] mean_u;
    logic [MEAN_W-1:0] mean_v;
    logic              index_error;
  } bin_update_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic                      panel_num_i     = 1'b0;
  logic                      cartridge_num_i = 1'b0;
  logic [1:0]                daq_num_i       = '0;
  logic [2:0]                chip_num_i      = '0;
  logic [1:0]                module_num_i    = '0;
  logic signed [FIELD_W-1:0] u_first_i       = '0;
  logic signed [FIELD_W-1:0] v_first_i       = '0;
  logic signed [FIELD_W-1:0] u_second_i      = '0;
  logic signed [FIELD_W-1:0] v_second_i      = '0;
  logic signed [FIELD_W-1:0] common_first_i  = '0;
  logic signed [FIELD_W-1:0] common_second_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic [BIN_W-1:0]          bin_index_o;
  logic                      diode_chosen_o;
  logic [CNT_W-1:0]          bin_count_o;
  logic signed [MEAN_W-1:0]  mean_u_out_o;
  logic signed [MEAN_W-1:0]  mean_v_out_o;
  logic                      index_error_o;

  // Local copy of the bin stores, cleared like the block's after reset.
  logic signed [MEAN_W-1:0] mean_u_bins [BIN_DEPTH];
  logic signed [MEAN_W-1:0] mean_v_bins [BIN_DEPTH];
  logic [CNT_W-1:0]         count_bins  [BIN_DEPTH];

  bin_update_t pending_updates[$];
  pos_event_t  hot_sites [HOT_SITES];
  int          fail_count  = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          steady      = 1'b0;

  per_channel_position_running_mean_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .panel_num_i     (panel_num_i),
    .cartridge_num_i (cartridge_num_i),
    .daq_num_i       (daq_num_i),
    .chip_num_i      (chip_num_i),
    .module_num_i    (module_num_i),
    .u_first_i       (u_first_i),
    .v_first_i       (v_first_i),
    .u_second_i      (u_second_i),
    .v_second_i      (v_second_i),
    .common_first_i  (common_first_i),
    .common_second_i (common_second_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bin_index_o     (bin_index_o),
    .diode_chosen_o  (diode_chosen_o),
    .bin_count_o     (bin_count_o),
    .mean_u_out_o    (mean_u_out_o),
    .mean_v_out_o    (mean_v_out_o),
    .index_error_o   (index_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Position sample taken from the low bits of a field as two's complement.
  function automatic longint position_of(input logic [FIELD_W-1:0] f);
    return longint'($signed(f[SAMPLE_BITS-1:0]));
  endfunction

  // One incremental mean step with truncating division and saturation.
  function automatic logic signed [MEAN_W-1:0] next_bin_mean(
      input logic signed [MEAN_W-1:0] mean, input longint x, input logic [CNT_W-1:0] cnt);
    longint acc;
    acc = longint'(mean) + (x * 256 - longint'(mean)) / longint'({1'b0, cnt});
    if (acc > longint'(MEAN_MAX)) acc = longint'(MEAN_MAX);
    if (acc < longint'(MEAN_MIN)) acc = longint'(MEAN_MIN);
    return acc[MEAN_W-1:0];
  endfunction

  // Applies one event to the local stores and returns the update it causes.
  function automatic bin_update_t accumulate_event(input pos_event_t ev);
    bin_update_t upd;
    logic        diode;
    int          idx;
    upd = '0;
    diode = $signed(ev.common_second) > $signed(ev.common_first);
    upd.diode_chosen = diode;
    // Out-of-range coordinates leave the stores alone.
    if (int'(ev.panel) >= PANELS || int'(ev.cartridge) >= CARTRIDGES ||
        int'(ev.daq) >= DAQS || int'(ev.chip) >= CHIPS || int'(ev.mod_num) >= MODULES) begin
      upd.index_error = 1'b1;
      return upd;
    end
    idx = ((((int'(ev.panel) * CARTRIDGES + int'(ev.cartridge)) * DAQS + int'(ev.daq))
           * CHIPS + int'(ev.chip)) * MODULES + int'(ev.mod_num)) * DIODES + int'(diode);
    if (idx >= BIN_DEPTH) idx = 0;
    if (count_bins[idx] != COUNT_MAX) count_bins[idx] = count_bins[idx] + 1'b1;
    mean_u_bins[idx] = next_bin_mean(mean_u_bins[idx],
                                     position_of(diode ? ev.u_second : ev.u_first),
                                     count_bins[idx]);
    mean_v_bins[idx] = next_bin_mean(mean_v_bins[idx],
                                     position_of(diode ? ev.v_second : ev.v_first),
                                     count_bins[idx]);
    upd.bin_index = idx[BIN_W-1:0];
    upd.bin_count = count_bins[idx];
    upd.mean_u    = mean_u_bins[idx];
    upd.mean_v    = mean_v_bins[idx];
    return upd;
  endfunction

  function automatic pos_event_t make_event(
      input logic p, input logic c, input logic [1:0] d, input logic [2:0] r,
      input logic [1:0] m, input logic [FIELD_W-1:0] uf, input logic [FIELD_W-1:0] vf,
      input logic [FIELD_W-1:0] us, input logic [FIELD_W-1:0] vs,
      input logic [FIELD_W-1:0] cf, input logic [FIELD_W-1:0] cs);
    pos_event_t ev;
    ev = '{p, c, d, r, m, uf, vf, us, vs, cf, cs};
    return ev;
  endfunction

  // Samples lean toward the extremes and toward small values now and then.
  function automatic logic [FIELD_W-1:0] random_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return FIELD_W'($urandom_range(16) - 8);
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic pos_event_t random_event();
    pos_event_t ev;
    ev = pos_event_t'({$urandom, $urandom, $urandom, $urandom});
    // Most events land on a few busy sites so their counts climb.
    if ($urandom_range(99) < 65) begin
      ev.panel     = hot_sites[$urandom_range(HOT_SITES - 1)].panel;
      ev.cartridge = hot_sites[$urandom_range(HOT_SITES - 1)].cartridge;
    end
    if ($urandom_range(99) < 65) begin
      int k;
      k = $urandom_range(HOT_SITES - 1);
      ev.panel     = hot_sites[k].panel;
      ev.cartridge = hot_sites[k].cartridge;
      ev.daq       = hot_sites[k].daq;
      ev.chip      = hot_sites[k].chip;
      ev.mod_num   = hot_sites[k].mod_num;
    end
    ev.u_first      = random_sample();
    ev.v_first      = random_sample();
    ev.u_second     = random_sample();
    ev.v_second     = random_sample();
    ev.common_first = random_sample();
    if ($urandom_range(9) == 0) begin
      ev.common_second = ev.common_first;
    end else begin
      ev.common_second = random_sample();
    end
    return ev;
  endfunction

  // Sends one event beat, then records the update it must produce.
  task automatic send_event(input pos_event_t ev);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < 34) gap++;
      if ($urandom_range(15) == 0) gap += $urandom_range(90);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    panel_num_i     <= ev.panel;
    cartridge_num_i <= ev.cartridge;
    daq_num_i       <= ev.daq;
    chip_num_i      <= ev.chip;
    module_num_i    <= ev.mod_num;
    u_first_i       <= ev.u_first;
    v_first_i       <= ev.v_first;
    u_second_i      <= ev.u_second;
    v_second_i      <= ev.v_second;
    common_first_i  <= ev.common_first;
    common_second_i <= ev.common_second;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_updates.push_back(accumulate_event(ev));
  endtask

  // Lowest and highest coordinates with the sample extremes.
  task automatic test_coordinate_extremes();
    send_event(make_event(1'b0, 1'b0, 2'd0, 3'd0, 2'd0, 16'h7FFF, 16'h7FFF, 16'h0000,
                          16'h0000, 16'h0000, 16'h0000));
    send_event(make_event(1'b1, 1'b1, 2'd3, 3'd7, 2'd3, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h7FFF));
    send_event(make_event(1'b1, 1'b1, 2'd3, 3'd7, 2'd3, 16'h7FFF, 16'h8000, 16'h0000,
                          16'h0000, 16'h7FFF, 16'h8000));
    send_event(make_event(1'b0, 1'b1, 2'd2, 3'd5, 2'd1, 16'hFFFF, 16'h0001, 16'h5555,
                          16'hAAAA, 16'h8000, 16'h8000));
  endtask

  // The second diode wins only on a strictly greater signed common signal.
  task automatic test_diode_selection();
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0010, 16'hFFF0, 16'h0100,
                          16'hFF00, 16'h0000, 16'h0001));
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0020, 16'hFFE0, 16'h0200,
                          16'hFE00, 16'h0001, 16'h0000));
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0030, 16'hFFD0, 16'h0300,
                          16'hFD00, 16'hFFFF, 16'h0000));
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0040, 16'hFFC0, 16'h0400,
                          16'hFC00, 16'h0000, 16'hFFFF));
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0050, 16'hFFB0, 16'h0500,
                          16'hFB00, 16'h7FFF, 16'h7FFF));
    send_event(make_event(1'b0, 1'b0, 2'd1, 3'd2, 2'd3, 16'h0060, 16'hFFA0, 16'h0600,
                          16'hFA00, 16'h8000, 16'h8001));
  endtask

  // Repeated updates of one bin with signs that make the division truncate.
  task automatic test_mean_truncation();
    logic [FIELD_W-1:0] u_seq [8];
    logic [FIELD_W-1:0] v_seq [8];
    u_seq = '{16'h0001, 16'hFFFF, 16'h0000, 16'h0003, 16'h8000, 16'h7FFF, 16'hFFF9, 16'h0002};
    v_seq = '{16'hFFFF, 16'h0001, 16'h0005, 16'hFFFD, 16'h7FFF, 16'h8000, 16'h0007, 16'hFFFE};
    foreach (u_seq[i]) begin
      send_event(make_event(1'b1, 1'b0, 2'd3, 3'd4, 2'd2, u_seq[i], v_seq[i], 16'h1234,
                            16'h4321, 16'h0001, 16'h0000));
    end
  endtask

  // Random events, with one stretch where neither side idles.
  task automatic test_random_events();
    // Busy sites are drawn directly so that no unset entry is ever copied.
    foreach (hot_sites[k]) hot_sites[k] = pos_event_t'({$urandom, $urandom, $urandom, $urandom});
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      steady = (n >= 300 && n < 420);
      send_event(random_event());
    end
    steady = 1'b0;
  endtask

  // Result side: random ready with occasional long stalls.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!steady && $urandom_range(63) == 0) begin
      stall_left  <= $urandom_range(80);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 34);
    end
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint act_v);
    if (fail_count < REPORT_LIMIT) begin
      $display("%t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
    fail_count++;
  endtask

  // Compare every result beat with the oldest outstanding update.
  always @(posedge clk_i) begin : check_updates
    bin_update_t exp_u;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected beat, bin_index", -1, longint'(bin_index_o));
      end else begin
        exp_u = pending_updates.pop_front();
        if (bin_index_o !== exp_u.bin_index)
          report_mismatch("bin_index", exp_u.bin_index, bin_index_o);
        if (diode_chosen_o !== exp_u.diode_chosen)
          report_mismatch("diode_chosen", exp_u.diode_chosen, diode_chosen_o);
        if (bin_count_o !== exp_u.bin_count)
          report_mismatch("bin_count", exp_u.bin_count, bin_count_o);
        if (mean_u_out_o !== exp_u.mean_u)
          report_mismatch("mean_u_out", $signed(exp_u.mean_u), mean_u_out_o);
        if (mean_v_out_o !== exp_u.mean_v)
          report_mismatch("mean_v_out", $signed(exp_u.mean_v), mean_v_out_o);
        if (index_error_o !== exp_u.index_error)
          report_mismatch("index_error", exp_u.index_error, index_error_o);
      end
    end
  end

  // Ends the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (count_bins[i]) begin
      mean_u_bins[i] = '0;
      mean_v_bins[i] = '0;
      count_bins[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_coordinate_extremes();
    test_diode_selection();
    test_mean_truncation();
    test_random_events();
    in_valid_i <= 1'b0;

    // Let every outstanding update arrive, then watch for stray beats.
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending_updates.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
